// ----- rtl/bkt_pkg.sv -----
`timescale 1ns / 1ps
package bkt_pkg;

    localparam int WordMaxDefault = 16;
    localparam int KwMaxLen       = 16;

    localparam logic [7:0] TK_NUMBER = 8'd130;
    localparam logic [7:0] TK_STRING = 8'd165;
    localparam logic [7:0] TK_NONE   = 8'd0;

    typedef enum logic [3:0] {
        MODE_IDLE = 4'b0001,
        MODE_NUM  = 4'b0010,
        MODE_STR  = 4'b0100,
        MODE_WORD = 4'b1000
    } mode_t;

    // kinds of token handed from front to back
    typedef enum logic [1:0] {
        KIND_NUMBER = 2'd0,
        KIND_STRING = 2'd1,
        KIND_WORD   = 2'd2
    } kind_t;

    // packed word: char i in bits [8*i +: 8]
    typedef struct packed {
        kind_t                     kind;
        logic                      too_long;
        logic [5:0]                length;
        logic [KwMaxLen*8-1:0]     chars;
    } tok_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    // keyword match: case-sensitive, words over KwMaxLen never match
    function automatic logic [7:0] kw_lookup(input logic [5:0] len,
                                             input logic [KwMaxLen*8-1:0] w);
        logic [7:0] code;
        code = TK_NONE;
        case (len)
            6'd2:
            begin
                case (w[15:0])
                    "OT": code = 8'd143; "FO": code = 8'd145; "FI": code = 8'd148;
                    "NO": code = 8'd153; "RO": code = 8'd171;
                    default: code = TK_NONE;
                endcase
            end
            6'd3:
            begin
                case (w[23:0])
                    "MER": code = 8'd131; "EYB": code = 8'd133; "SLC": code = 8'd136;
                    "DNE": code = 8'd140; "ROF": code = 8'd142; "TEL": code = 8'd150;
                    "WEN": code = 8'd152; "POP": code = 8'd157; "SYS": code = 8'd166;
                    "DNA": code = 8'd170; "TON": code = 8'd176; "ERF": code = 8'd177;
                    "DNR": code = 8'd178; "SBA": code = 8'd180; "NTA": code = 8'd181;
                    "RHC": code = 8'd182; "SOC": code = 8'd184; "PXE": code = 8'd185;
                    "XIF": code = 8'd186; "TNI": code = 8'd187; "NEL": code = 8'd189;
                    "NIL": code = 8'd190; "RTS": code = 8'd191; "GOL": code = 8'd192;
                    "NGS": code = 8'd194; "DIM": code = 8'd198; "GES": code = 8'd199;
                    "RLC": code = 8'd208; "MID": code = 8'd209; "TEG": code = 8'd210;
                    "NUR": code = 8'd220; "NIS": code = 8'd221; "NAT": code = 8'd222;
                    "RQS": code = 8'd224; "CSA": code = 8'd230; "LAV": code = 8'd232;
                    "ROX": code = 8'd233; "CPS": code = 8'd234; "BAT": code = 8'd235;
                    "SOP": code = 8'd236; "RSU": code = 8'd237;
                    default: code = TK_NONE;
                endcase
            end
            6'd4:
            begin
                case (w[31:0])
                    "LLAC": code = 8'd134; "ATAD": code = 8'd138; "TIXE": code = 8'd141;
                    "NEHT": code = 8'd147; "OTOG": code = 8'd149; "TXEN": code = 8'd151;
                    "ESAB": code = 8'd155; "EKOP": code = 8'd156; "DAER": code = 8'd161;
                    "POTS": code = 8'd164; "TIAW": code = 8'd169; "EMIT": code = 8'd179;
                    "GOLC": code = 8'd183; "KEEP": code = 8'd193; "TFEL": code = 8'd195;
                    "TSIL": code = 8'd211; "PETS": code = 8'd212; "NEPO": code = 8'd213;
                    "CARF": code = 8'd226; "TNIC": code = 8'd227; "GNSC": code = 8'd228;
                    "LBDC": code = 8'd229;
                    default: code = TK_NONE;
                endcase
            end
            6'd5:
            begin
                case (w[39:0])
                    "BUSOG": code = 8'd144; "TUPNI": code = 8'd146; "TNIRP": code = 8'd158;
                    "GNISU": code = 8'd159;
                    "ESACL": code = 8'd188; "THGIR": code = 8'd196; "GNRTS": code = 8'd197;
                    "RAELC": code = 8'd207; "ESOLC": code = 8'd214; "ESACU": code = 8'd223;
                    default: code = TK_NONE;
                endcase
            end
            6'd6:
            begin
                case (w[47:0])
                    "EGNAHC": code = 8'd135; "NOITPO": code = 8'd154; "NRUTER": code = 8'd163;
                    "GNIRTS": code = 8'd165; "EL_PMC": code = 8'd172; "EG_PMC": code = 8'd173;
                    "EN_PMC": code = 8'd174; "RTSBUS": code = 8'd200; "ELBUOD": code = 8'd203;
                    "ELGNIS": code = 8'd204; "SUTATS": code = 8'd215; "RTSFED": code = 8'd238;
                    "TNIFED": code = 8'd239; "GNSFED": code = 8'd240; "LBDFED": code = 8'd231;
                    default: code = TK_NONE;
                endcase
            end
            6'd7:
            begin
                case (w[55:0])
                    "EROTSER": code = 8'd162; "TSILRAV": code = 8'd168;
                    "REGETNI": code = 8'd205; "MERGNAB": code = 8'd206;
                    "TREVNOC": code = 8'd225;
                    default: code = TK_NONE;
                endcase
            end
            6'd8:
            begin
                case (w[63:0])
                    "MERETOUQ": code = 8'd132; "RTS_EMIT": code = 8'd167;
                    "HSAH_PMC": code = 8'd175; "ELIF_TEG": code = 8'd218;
                    "ELIF_TUP": code = 8'd219;
                    default: code = TK_NONE;
                endcase
            end
            6'd9:
            begin
                case (w[71:0])
                    "EZIMODNAR": code = 8'd160;
                    default: code = TK_NONE;
                endcase
            end
            6'd10:
            begin
                case (w[79:0])
                    "ELIF_TNIRP": code = 8'd216; "ELIF_TUPNI": code = 8'd217;
                    default: code = TK_NONE;
                endcase
            end
            6'd13:
            begin
                case (w[103:0])
                    "EMAN_NOITCNUF": code = 8'd201; "EMAN_ELBAIRAV": code = 8'd202;
                    default: code = TK_NONE;
                endcase
            end
            default: code = TK_NONE;
        endcase
        return code;
    endfunction

endpackage

// ----- rtl/basic_keyword_tokenizer.sv -----
`timescale 1ns / 1ps
// basic_keyword_tokenizer: byte-serial lexer for BASIC source text
// input channel s_axis: tdata = char_in, tuser = flush (end of text)
// output channel m_axis: tdata = token code (0 unknown word, 130 number,
// 165 string, other values keyword codes)
// one byte is taken per cycle while s_axis_tready is high; a token that a
// byte closes reaches m_axis via front and back registers (two register stages)
// the front stage tracks lexer mode and the word buffer; the back stage
// looks the word up in the keyword table and holds the result register
// reset clears the mode to idle and empties both stages
// a stall on m_axis fills the stage between front and back, after which
// s_axis_tready drops until the receiver takes the waiting result
module basic_keyword_tokenizer #(
    parameter int WORD_MAX = bkt_pkg::WordMaxDefault
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] char_in
    input  logic       s_axis_tuser,   // [0] flush
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [7:0] token_code
);
    logic          tok_valid, tok_ready;
    bkt_pkg::tok_t tok;

    bkt_front #(.WORD_MAX(WORD_MAX)) u_front (
        .clk, .rst_n,
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .char_in(s_axis_tdata), .flush(s_axis_tuser),
        .tok_valid, .tok_ready, .tok
    );

    bkt_back u_back (
        .clk, .rst_n, .tok_valid, .tok_ready, .tok,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
    );
endmodule

// ----- rtl/bkt_front.sv -----
`timescale 1ns / 1ps
module bkt_front #(
    parameter int WORD_MAX = bkt_pkg::WordMaxDefault
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    char_in,
    input  logic          flush,
    output logic          tok_valid,
    input  logic          tok_ready,
    output bkt_pkg::tok_t tok
);
    localparam int LW = $clog2(WORD_MAX + 1);
    localparam int IW = $clog2(WORD_MAX);

    bkt_pkg::mode_t mode_reg, mode_next;
    logic [LW-1:0]  len_reg, len_next;
    logic           long_reg, long_next;
    logic [7:0]     chars_reg [WORD_MAX];
    logic           wr_en;
    logic [IW-1:0]  wr_idx;
    logic [7:0]     wr_data;
    logic           emit;
    bkt_pkg::kind_t emit_kind;
    logic           go;
    logic           dig, let_c, quo;

    assign in_ready = !tok_valid || tok_ready;
    assign go       = in_valid && in_ready;
    assign dig      = bkt_pkg::is_digit(char_in);
    assign let_c    = bkt_pkg::is_letter(char_in);
    assign quo      = (char_in == 8'h22);

    // classify byte against current mode
    always_comb
    begin
        mode_next = mode_reg;
        len_next  = len_reg;
        long_next = long_reg;
        wr_en     = 1'b0;
        wr_idx    = '0;
        wr_data   = char_in;
        emit      = 1'b0;
        emit_kind = bkt_pkg::KIND_WORD;
        if (flush)
        begin
            emit      = (mode_reg != bkt_pkg::MODE_IDLE);
            emit_kind = (mode_reg == bkt_pkg::MODE_NUM) ? bkt_pkg::KIND_NUMBER :
                        (mode_reg == bkt_pkg::MODE_STR) ? bkt_pkg::KIND_STRING :
                        bkt_pkg::KIND_WORD;
            mode_next = bkt_pkg::MODE_IDLE;
            len_next  = '0;
            long_next = 1'b0;
        end
        else
        begin
            logic start;
            start = 1'b0;
            case (mode_reg)
                bkt_pkg::MODE_NUM:
                begin
                    if (!dig)
                    begin
                        emit      = 1'b1;
                        emit_kind = bkt_pkg::KIND_NUMBER;
                        start     = 1'b1;
                    end
                end
                bkt_pkg::MODE_STR:
                begin
                    if (quo)
                    begin
                        emit      = 1'b1;
                        emit_kind = bkt_pkg::KIND_STRING;
                        mode_next = bkt_pkg::MODE_IDLE;
                    end
                end
                bkt_pkg::MODE_WORD:
                begin
                    if (let_c || char_in == 8'h5F)
                    begin
                        if (len_reg < LW'(WORD_MAX))
                        begin
                            wr_en    = 1'b1;
                            wr_idx   = len_reg[IW-1:0];
                            len_next = len_reg + 1'b1;
                        end
                        else
                        begin
                            long_next = 1'b1;
                        end
                    end
                    else
                    begin
                        emit  = 1'b1;
                        start = 1'b1;
                    end
                end
                default: start = 1'b1;
            endcase
            if (start)
            begin
                len_next  = '0;
                long_next = 1'b0;
                if (dig)
                    mode_next = bkt_pkg::MODE_NUM;
                else if (quo)
                    mode_next = bkt_pkg::MODE_STR;
                else if (let_c)
                begin
                    mode_next = bkt_pkg::MODE_WORD;
                    wr_en     = 1'b1;
                    wr_idx    = '0;
                    len_next  = LW'(1);
                end
                else
                    mode_next = bkt_pkg::MODE_IDLE;
            end
        end
    end

    // mode and length state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= bkt_pkg::MODE_IDLE;
            len_reg   <= '0;
            long_reg  <= 1'b0;
            tok_valid <= 1'b0;
        end
        else if (go)
        begin
            mode_reg  <= mode_next;
            len_reg   <= len_next;
            long_reg  <= long_next;
            tok_valid <= emit;
        end
        else if (tok_ready)
        begin
            tok_valid <= 1'b0;
        end
    end

    // word buffer and token capture
    always_ff @(posedge clk)
    begin
        if (go && wr_en)
            chars_reg[wr_idx] <= wr_data;
        if (go && emit)
        begin
            tok.kind     <= emit_kind;
            tok.too_long <= long_reg || (int'(len_reg) > bkt_pkg::KwMaxLen);
            tok.length   <= 6'(len_reg);
            for (int i = 0; i < bkt_pkg::KwMaxLen; i++)
                tok.chars[8*i +: 8] <= (i < WORD_MAX && i < int'(len_reg)) ?
                                       chars_reg[i % WORD_MAX] : 8'h00;
        end
    end

    // a token only leaves on a transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && !tok_ready |=> tok_valid && $stable(tok))
        else $error("token dropped under stall");
    assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LW'(WORD_MAX))
        else $error("length overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg != bkt_pkg::MODE_WORD |-> len_reg == '0)
        else $error("stale length");
endmodule

// ----- rtl/bkt_back.sv -----
`timescale 1ns / 1ps
module bkt_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          tok_valid,
    output logic          tok_ready,
    input  bkt_pkg::tok_t tok,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [7:0]    m_axis_tdata
);
    logic [7:0] code;

    assign tok_ready = !m_axis_tvalid || m_axis_tready;

    // resolve token code
    always_comb
    begin
        case (tok.kind)
            bkt_pkg::KIND_NUMBER: code = bkt_pkg::TK_NUMBER;
            bkt_pkg::KIND_STRING: code = bkt_pkg::TK_STRING;
            default: code = tok.too_long ? bkt_pkg::TK_NONE :
                            bkt_pkg::kw_lookup(tok.length, tok.chars);
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tvalid <= 1'b0;
        else if (tok_ready)
            m_axis_tvalid <= tok_valid;
    end

    always_ff @(posedge clk)
    begin
        if (tok_ready && tok_valid)
            m_axis_tdata <= code;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result lost under stall");
    assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_ready |=> m_axis_tvalid)
        else $error("token not forwarded");
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata == 8'd0 || m_axis_tdata >= 8'd130)
        else $error("bad code");
endmodule
